// File: design/tff_pkg.sv
// shared types and constants of the tcp flow-follow filter
// no dependencies; imported by every design file
package tff_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int SLOT_W      = 4;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VER_4       = 4'd4;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [1:0]  KIND_TCP       = 2'd3;
    localparam logic [7:0]  BUDGET_FREE    = 8'd2;
    localparam logic [7:0]  BUDGET_RESET   = 8'd5;

    localparam logic [2:0] REG_RULE_KIND      = 3'd0;
    localparam logic [2:0] REG_ON_CHECK_EN    = 3'd1;
    localparam logic [2:0] REG_ON_FLAG_MASK   = 3'd2;
    localparam logic [2:0] REG_OFF_CHECK_EN   = 3'd3;
    localparam logic [2:0] REG_OFF_FLAG_MASK  = 3'd4;
    localparam logic [2:0] REG_IGNORE_MODE    = 3'd5;
    localparam logic [2:0] REG_ACTION_DONE    = 3'd6;
    localparam logic [2:0] REG_FOLLOW_BUDGET  = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] ports;
    } key_t;

    typedef struct packed {
        logic             active;
        logic             found;
        logic [IDX_W-1:0] hit_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } token_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } wr_t;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// File: design/tcp_flow_follow_filter.sv
// top level: config registers, packet classification and sequencing
// depends on tff_pkg and tff_chain
// A packet header is one input beat and gives exactly one result beat. A header
// that is not IPv4 TCP, or that arrives while the rule kind is not tcp, goes
// straight to the finish state without a search. A TCP header is searched in
// the flow table: a search token steps through the row of table cells one cell
// per cycle, then the finish state applies the allocation and loads the result
// register once the output is free. One header is in work at a time; the next is
// accepted once the result has been loaded, even while that result is stalled.
// No clearing pass is needed after reset.
module tcp_flow_follow_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] ether_type,
    input  logic [3:0]  ip_ver,
    input  logic [7:0]  ip_protocol,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [7:0]  tcp_flags,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_tcp,
    output logic        flow_hit,
    output logic        fire,
    output logic [3:0]  slot
);
    import tff_pkg::*;

    logic [1:0] rule_kind_reg;
    logic       on_check_enable_reg;
    logic [7:0] on_flag_mask_reg;
    logic       off_check_enable_reg;
    logic [7:0] off_flag_mask_reg;
    logic       ignore_mode_reg;
    logic       action_done_reg;
    logic [7:0] follow_budget_reg;

    state_t           state_reg, state_next;
    logic             start_reg;
    key_t             key_reg;
    logic             is_tcp_reg, applies_reg, cond_reg, enable_reg;
    token_t           res_reg;
    logic [IDX_W-1:0] victim_reg;
    logic             out_valid_reg, out_is_tcp_reg, out_hit_reg, out_fire_reg;
    logic [3:0]       out_slot_reg;

    logic             cfg_write;
    logic             accept;
    logic             in_is_tcp, in_applies, on_ok, off_ok;
    logic             out_free;
    logic             load_out;
    wr_t              wr;
    logic [IDX_W-1:0] alloc_idx;
    token_t           last_token;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_kind_reg        <= KIND_TCP;
            on_check_enable_reg  <= 1'b0;
            on_flag_mask_reg     <= 8'd0;
            off_check_enable_reg <= 1'b0;
            off_flag_mask_reg    <= 8'd0;
            ignore_mode_reg      <= 1'b0;
            action_done_reg      <= 1'b0;
            follow_budget_reg    <= BUDGET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_RULE_KIND:     rule_kind_reg        <= pwdata[1:0];
                REG_ON_CHECK_EN:   on_check_enable_reg  <= pwdata[0];
                REG_ON_FLAG_MASK:  on_flag_mask_reg     <= pwdata[7:0];
                REG_OFF_CHECK_EN:  off_check_enable_reg <= pwdata[0];
                REG_OFF_FLAG_MASK: off_flag_mask_reg    <= pwdata[7:0];
                REG_IGNORE_MODE:   ignore_mode_reg      <= pwdata[0];
                REG_ACTION_DONE:   action_done_reg      <= pwdata[0];
                REG_FOLLOW_BUDGET: follow_budget_reg    <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_RULE_KIND:     prdata = 32'(rule_kind_reg);
            REG_ON_CHECK_EN:   prdata = 32'(on_check_enable_reg);
            REG_ON_FLAG_MASK:  prdata = 32'(on_flag_mask_reg);
            REG_OFF_CHECK_EN:  prdata = 32'(off_check_enable_reg);
            REG_OFF_FLAG_MASK: prdata = 32'(off_flag_mask_reg);
            REG_IGNORE_MODE:   prdata = 32'(ignore_mode_reg);
            REG_ACTION_DONE:   prdata = 32'(action_done_reg);
            REG_FOLLOW_BUDGET: prdata = 32'(follow_budget_reg);
        endcase
    end

    // header classification
    assign in_is_tcp  = (ether_type == ETHERTYPE_IPV4) && (ip_ver == IP_VER_4)
                        && (ip_protocol == PROTO_TCP);
    assign in_applies = in_is_tcp && (rule_kind_reg == KIND_TCP);
    assign on_ok      = !(on_check_enable_reg
                          && ((tcp_flags & on_flag_mask_reg) != on_flag_mask_reg));
    assign off_ok     = !(off_check_enable_reg
                          && ((~tcp_flags & off_flag_mask_reg) != off_flag_mask_reg));

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_applies ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (last_token.active)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign alloc_idx = res_reg.free_found ? res_reg.free_idx : victim_reg;

    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        accept   = (state_reg == ST_IDLE) && in_valid;
        load_out = (state_reg == ST_FINISH) && out_free;
        wr.en    = load_out && applies_reg && enable_reg && cond_reg && !res_reg.found;
        wr.idx   = alloc_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            victim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept && in_applies;
            if (wr.en && !res_reg.free_found)
            begin
                victim_reg <= (victim_reg == IDX_W'(NUM_ENTRIES - 1)) ? '0
                              : victim_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.src_addr <= src_addr;
            key_reg.dst_addr <= dst_addr;
            key_reg.ports    <= {src_port, dst_port};
            is_tcp_reg       <= in_is_tcp;
            applies_reg      <= in_applies;
            cond_reg         <= on_ok && off_ok;
            enable_reg       <= !ignore_mode_reg && !action_done_reg;
        end
        if (last_token.active)
        begin
            res_reg <= last_token;
        end
        if (load_out)
        begin
            out_is_tcp_reg <= is_tcp_reg;
            out_hit_reg    <= applies_reg && res_reg.found;
            out_fire_reg   <= applies_reg && enable_reg && (res_reg.found || cond_reg);
            if (applies_reg && res_reg.found)
            begin
                out_slot_reg <= to_slot(res_reg.hit_idx);
            end
            else if (wr.en)
            begin
                out_slot_reg <= to_slot(alloc_idx);
            end
            else
            begin
                out_slot_reg <= '0;
            end
        end
    end

    tff_chain u_chain (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start_reg),
        .key           (key_reg),
        .wr            (wr),
        .follow_budget (follow_budget_reg),
        .last_token    (last_token)
    );

    assign out_valid = out_valid_reg;
    assign is_tcp    = out_is_tcp_reg;
    assign flow_hit  = out_hit_reg;
    assign fire      = out_fire_reg;
    assign slot      = out_slot_reg;

`ifndef SYNTHESIS
    a_hit_is_tcp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (flow_hit || fire) |-> is_tcp)
        else $error("hit or fire on a packet that is not tcp");

    a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !flow_hit && !fire |-> slot == '0)
        else $error("slot set without hit or allocation");

    a_victim_moves_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(victim_reg) |-> $past(wr.en))
        else $error("victim pointer moved without an allocation");

    a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(victim_reg) < NUM_ENTRIES)
        else $error("victim pointer out of range");

    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        last_token.active |-> state_reg == ST_SCAN)
        else $error("search token finished outside a scan");
`endif

endmodule

// File: design/tff_cell.sv
// one flow table entry with its compare and update logic
// depends on tff_pkg; instantiated by tff_chain
module tff_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [tff_pkg::IDX_W-1:0] cell_idx,
    input  tff_pkg::key_t        key,
    input  tff_pkg::wr_t         wr,
    input  logic [7:0]           follow_budget,
    input  tff_pkg::token_t      token_in,
    output tff_pkg::token_t      token_out
);
    import tff_pkg::*;

    logic        valid_reg, valid_next;
    key_t        key_reg;
    logic [7:0]  budget_reg, budget_next;
    token_t      token_reg, token_next;
    logic        match;
    logic        take_hit;
    logic        write_me;

    assign match    = valid_reg && (key_reg == key);
    assign take_hit = token_in.active && !token_in.found && match;
    assign write_me = wr.en && (wr.idx == cell_idx);

    always_comb
    begin
        token_next = token_in;
        if (take_hit)
        begin
            token_next.found   = 1'b1;
            token_next.hit_idx = cell_idx;
        end
        if (token_in.active && !valid_reg && !token_in.free_found)
        begin
            token_next.free_found = 1'b1;
            token_next.free_idx   = cell_idx;
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        budget_next = budget_reg;
        if (write_me)
        begin
            valid_next  = 1'b1;
            budget_next = follow_budget;
        end
        else if (take_hit)
        begin
            budget_next = budget_reg - 8'd1;
            if (budget_reg == BUDGET_FREE)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            token_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        budget_reg <= budget_next;
        if (write_me)
        begin
            key_reg <= key;
        end
    end

    assign token_out = token_reg;

endmodule

// File: design/tff_chain.sv
// row of flow table cells; a search token walks one cell per cycle
// depends on tff_pkg and tff_cell
module tff_chain (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tff_pkg::key_t   key,
    input  tff_pkg::wr_t    wr,
    input  logic [7:0]      follow_budget,
    output tff_pkg::token_t last_token
);
    import tff_pkg::*;

    token_t link [NUM_ENTRIES+1];

    assign link[0] = {start, {(2 * IDX_W + 2){1'b0}}};

    for (genvar k = 0; k < NUM_ENTRIES; k++)
    begin : g_cell
        tff_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_idx      (IDX_W'(k)),
            .key           (key),
            .wr            (wr),
            .follow_budget (follow_budget),
            .token_in      (link[k]),
            .token_out     (link[k+1])
        );
    end

    assign last_token = link[NUM_ENTRIES];

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench for tcp_flow_follow_filter: directed header table, then random phases of
// flow traffic, every result beat checked against the expected values of the table rows or a flow-table predictor
// depends on tff_pkg and the tcp_flow_follow_filter design files
module tb;
    import tff_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 160;
    localparam int LAST_PHASE     = 11;
    localparam int POOL_SIZE      = 24;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 24;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [3:0]  ip_ver;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
    } header_t;

    typedef struct packed {
        logic       is_tcp;
        logic       flow_hit;
        logic       fire;
        logic [3:0] slot;
    } verdict_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       on_en;
        logic [7:0] on_mask;
        logic       off_en;
        logic [7:0] off_mask;
        logic       ignore;
        logic       done;
        logic [7:0] budget;
    } rules_t;

    typedef struct packed {
        header_t  hdr;
        logic     typed;
        verdict_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] ether_type;
    logic [3:0]  ip_ver;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
    logic        out_valid;
    logic        out_stall;
    logic        is_tcp;
    logic        flow_hit;
    logic        fire;
    logic [3:0]  slot;

    rules_t      rules;
    logic        flow_live [NUM_ENTRIES];
    key_t        flow_key [NUM_ENTRIES];
    logic [7:0]  flow_budget [NUM_ENTRIES];
    int          victim_slot;
    key_t        flow_pool [POOL_SIZE];
    verdict_t    pending_verdicts[$];
    row_t        header_table[$];
    verdict_t    head;
    int          mismatches;
    int          results_seen;
    int          idle_pct;

    tcp_flow_follow_filter dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .ether_type(ether_type),
        .ip_ver(ip_ver),
        .ip_protocol(ip_protocol),
        .src_addr(src_addr),
        .dst_addr(dst_addr),
        .src_port(src_port),
        .dst_port(dst_port),
        .tcp_flags(tcp_flags),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .is_tcp(is_tcp),
        .flow_hit(flow_hit),
        .fire(fire),
        .slot(slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // flow-table predictor: classifies one header and updates the table copy
    function automatic verdict_t judge_header(input header_t h);
        verdict_t   v;
        key_t       key;
        logic [7:0] old;
        logic       on_ok;
        logic       off_ok;
        int         k;
        int         pick;
        v = '0;
        key = {h.src_addr, h.dst_addr, h.src_port, h.dst_port};
        if (h.ether_type == ETHERTYPE_IPV4 && h.ip_ver == IP_VER_4
            && h.ip_protocol == PROTO_TCP)
        begin
            v.is_tcp = 1'b1;
            if (rules.kind == KIND_TCP)
            begin
                for (k = 0; k < NUM_ENTRIES && !v.flow_hit; k++)
                begin
                    if (flow_live[k] && flow_key[k] == key)
                    begin
                        old = flow_budget[k];
                        flow_budget[k] = old - 8'd1;
                        if (old == BUDGET_FREE)
                            flow_live[k] = 1'b0;
                        v.flow_hit = 1'b1;
                        v.slot = 4'(k);
                    end
                end
                on_ok = !(rules.on_en && (h.tcp_flags & rules.on_mask) != rules.on_mask);
                off_ok = !(rules.off_en && (~h.tcp_flags & rules.off_mask) != rules.off_mask);
                if ((v.flow_hit || (on_ok && off_ok)) && !rules.ignore && !rules.done)
                begin
                    v.fire = 1'b1;
                    if (!v.flow_hit)
                    begin
                        pick = -1;
                        for (k = 0; k < NUM_ENTRIES; k++)
                            if (!flow_live[k] && pick < 0)
                                pick = k;
                        if (pick < 0)
                        begin
                            pick = victim_slot;
                            victim_slot = (victim_slot + 1 >= NUM_ENTRIES) ? 0 : victim_slot + 1;
                        end
                        flow_live[pick] = 1'b1;
                        flow_budget[pick] = rules.budget;
                        flow_key[pick] = key;
                        v.slot = 4'(pick);
                    end
                end
            end
        end
        return v;
    endfunction

    function automatic logic [31:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_RULE_KIND:     return 32'(rules.kind);
            REG_ON_CHECK_EN:   return 32'(rules.on_en);
            REG_ON_FLAG_MASK:  return 32'(rules.on_mask);
            REG_OFF_CHECK_EN:  return 32'(rules.off_en);
            REG_OFF_FLAG_MASK: return 32'(rules.off_mask);
            REG_IGNORE_MODE:   return 32'(rules.ignore);
            REG_ACTION_DONE:   return 32'(rules.done);
            default:           return 32'(rules.budget);
        endcase
    endfunction

    function automatic header_t make_header(input logic [15:0] et, input logic [3:0] ver,
                                            input logic [7:0] proto, input logic [31:0] sa,
                                            input logic [31:0] da, input logic [15:0] sp,
                                            input logic [15:0] dp, input logic [7:0] fl);
        header_t h;
        h.ether_type = et;
        h.ip_ver = ver;
        h.ip_protocol = proto;
        h.src_addr = sa;
        h.dst_addr = da;
        h.src_port = sp;
        h.dst_port = dp;
        h.tcp_flags = fl;
        return h;
    endfunction

    function automatic logic [7:0] pick_flags();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly pooled flows so that hits, frees and victims happen; the rest noise
    function automatic header_t build_header();
        header_t h;
        key_t    key;
        int      r;
        r = $urandom_range(0, 99);
        key = flow_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 20)
            key = {$urandom, $urandom, $urandom};
        h = make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, key.src_addr, key.dst_addr,
                        key.ports[31:16], key.ports[15:0], pick_flags());
        if (r < 8)
        begin
            h.ether_type = 16'($urandom);
            h.ip_ver = 4'($urandom);
            h.ip_protocol = 8'($urandom);
        end
        else if (r < 14)
        begin
            case ($urandom_range(0, 2))
                0: h.ether_type = ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15));
                1: h.ip_ver = IP_VER_4 ^ (4'd1 << $urandom_range(0, 3));
                default: h.ip_protocol = PROTO_TCP ^ (8'd1 << $urandom_range(0, 7));
            endcase
        end
        return h;
    endfunction

    task automatic add_row(input header_t h, input logic typed, input logic tcp_bit,
                           input logic hit_bit, input logic fire_bit, input logic [3:0] slot_val);
        row_t r;
        r.hdr = h;
        r.typed = typed;
        r.want = {tcp_bit, hit_bit, fire_bit, slot_val};
        header_table.push_back(r);
    endtask

    // offers one header and waits until it is accepted; valid stays high on return unless an idle gap follows
    task automatic send_header(input header_t h, input logic typed, input verdict_t want);
        verdict_t v;
        int       gap;
        in_valid <= 1'b1;
        ether_type <= h.ether_type;
        ip_ver <= h.ip_ver;
        ip_protocol <= h.ip_protocol;
        src_addr <= h.src_addr;
        dst_addr <= h.dst_addr;
        src_port <= h.src_port;
        dst_port <= h.dst_port;
        tcp_flags <= h.tcp_flags;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        v = judge_header(h);
        pending_verdicts.push_back(typed ? want : v);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_RULE_KIND:     rules.kind = value[1:0];
            REG_ON_CHECK_EN:   rules.on_en = value[0];
            REG_ON_FLAG_MASK:  rules.on_mask = value[7:0];
            REG_OFF_CHECK_EN:  rules.off_en = value[0];
            REG_OFF_FLAG_MASK: rules.off_mask = value[7:0];
            REG_IGNORE_MODE:   rules.ignore = value[0];
            REG_ACTION_DONE:   rules.done = value[0];
            default:           rules.budget = value[7:0];
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (prdata !== reg_value(idx))
        begin
            $error("register %0d: expected %0h, got %0h", idx, reg_value(idx), prdata);
            mismatches++;
        end
        @(posedge clk);
    endtask

    task automatic apply_rules(input logic [1:0] kind, input logic on_en, input logic [7:0] on_mask,
                               input logic off_en, input logic [7:0] off_mask,
                               input logic ignore, input logic done, input logic [7:0] budget);
        write_reg(REG_RULE_KIND, 32'(kind));
        write_reg(REG_ON_CHECK_EN, 32'(on_en));
        write_reg(REG_ON_FLAG_MASK, 32'(on_mask));
        write_reg(REG_OFF_CHECK_EN, 32'(off_en));
        write_reg(REG_OFF_FLAG_MASK, 32'(off_mask));
        write_reg(REG_IGNORE_MODE, 32'(ignore));
        write_reg(REG_ACTION_DONE, 32'(done));
        write_reg(REG_FOLLOW_BUDGET, 32'(budget));
    endtask

    // result beats against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                head = pending_verdicts.pop_front();
                if (is_tcp !== head.is_tcp)
                begin
                    $error("is_tcp: expected %0d, got %0d", head.is_tcp, is_tcp);
                    mismatches++;
                end
                if (flow_hit !== head.flow_hit)
                begin
                    $error("flow_hit: expected %0d, got %0d", head.flow_hit, flow_hit);
                    mismatches++;
                end
                if (fire !== head.fire)
                begin
                    $error("fire: expected %0d, got %0d", head.fire, fire);
                    mismatches++;
                end
                if (slot !== head.slot)
                begin
                    $error("slot: expected %0d, got %0d", head.slot, slot);
                    mismatches++;
                end
            end
        end
    end

    // receiver: random stall bursts and one long hold-off
    initial
    begin
        bit held;
        held = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                stuck = 0;
            else
                stuck++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        int      phase;
        int      n;
        int      k;
        header_t h;
        key_t    key;
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        ether_type <= '0;
        ip_ver <= '0;
        ip_protocol <= '0;
        src_addr <= '0;
        dst_addr <= '0;
        src_port <= '0;
        dst_port <= '0;
        tcp_flags <= '0;
        mismatches = 0;
        results_seen = 0;
        idle_pct = 30;
        rules = {KIND_TCP, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, BUDGET_RESET};
        for (k = 0; k < NUM_ENTRIES; k++)
        begin
            flow_live[k] = 1'b0;
            flow_key[k] = '0;
            flow_budget[k] = '0;
        end
        victim_slot = 0;
        for (k = 0; k < POOL_SIZE; k++)
        begin
            key = {$urandom, $urandom, $urandom};
            if (k % 3 != 0)
            begin
                key = flow_pool[k - 1];
                case ($urandom_range(0, 3))
                    0: key.src_addr = $urandom;
                    1: key.dst_addr = $urandom;
                    2: key.ports[31:16] = 16'($urandom);
                    default: key.ports[15:0] = 16'($urandom);
                endcase
            end
            flow_pool[k] = key;
        end

        // default rules: tcp kind, no flag tests, budget of five
        add_row(make_header(16'h86DD, 4'd6, PROTO_TCP, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
        add_row(make_header(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, 8'd17, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
        add_row(make_header(16'hFFFF, 4'hF, 8'hFF, '1, '1, '1, '1, '1), 1, 0, 0, 0, 0);
        add_row(make_header(16'h0000, IP_VER_4, PROTO_TCP, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 0, 0, 0, 0, 0),
                1, 1, 0, 1, 0);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 0, 0, 0, 0, 0),
                1, 1, 1, 1, 0);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, '1, '1, '1, '1, '1),
                1, 1, 0, 1, 1);
        // budget runs out on the third further hit, then the slot is reused
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 0, 0, 0, 0, 8'h12),
                1, 1, 1, 1, 0);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 0, 0, 0, 0, 8'h10),
                1, 1, 1, 1, 0);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 0, 0, 0, 0, 8'h11),
                1, 1, 1, 1, 0);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 0, 0, 0, 0, 8'h02),
                1, 1, 0, 1, 0);
        // partial key matches are new flows; the full all-ones key hits its flow again
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 0, 1, 0, 0, 0),
                1, 1, 0, 1, 2);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 0, 1, 1, 0, 0),
                1, 1, 0, 1, 3);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 0, 1, 1, 16'h8000, 0),
                1, 1, 0, 1, 4);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, '1, '1, '1, '1, 0),
                1, 1, 1, 1, 1);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 32'h8000_0001,
                            32'h7FFF_FFFE, 16'h1234, 16'hFEDC, 8'hA5), 0, 0, 0, 0, 0);
        add_row(make_header(ETHERTYPE_IPV4, IP_VER_4, PROTO_TCP, 32'h8000_0001,
                            32'h7FFF_FFFE, 16'h1234, 16'hFEDC, 8'h5A), 0, 0, 0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (header_table[k])
            send_header(header_table[k].hdr, header_table[k].typed, header_table[k].want);
        in_valid <= 1'b0;
        wait_drained();

        for (phase = 1; phase <= LAST_PHASE; phase++)
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (phase)
                1: apply_rules(KIND_TCP, 0, 8'h00, 0, 8'h00, 0, 0, BUDGET_RESET);
                2: apply_rules(KIND_TCP, 1, 8'(1 << $urandom_range(0, 7)), 0, 8'h00, 0, 0, 8'hFF);
                3: apply_rules(KIND_TCP, 0, 8'h00, 1, 8'(1 << $urandom_range(0, 7)), 0, 0,
                               BUDGET_FREE);
                4: apply_rules(2'd1, 1, 8'h55, 1, 8'hAA, 0, 0, 8'd7);
                5: apply_rules(KIND_TCP, 0, 8'h00, 0, 8'h00, 1, 0, BUDGET_RESET);
                6: apply_rules(KIND_TCP, 0, 8'h00, 0, 8'h00, 0, 1, 8'd3);
                7: apply_rules(KIND_TCP, 1, 8'hFF, 1, 8'h00, 0, 0, 8'd0);
                8: apply_rules(KIND_TCP, 1, 8'h00, 1, 8'hFF, 0, 0, 8'd1);
                9: apply_rules(2'd0, 0, 8'h00, 0, 8'h00, 0, 0, BUDGET_RESET);
                10: apply_rules(2'd2, 1, 8'h01, 0, 8'h00, 1, 1, 8'd4);
                default: apply_rules(KIND_TCP, 1, 8'($urandom) & 8'($urandom), 1,
                                     8'($urandom) & 8'($urandom), 0, 0,
                                     8'($urandom_range(2, 6)));
            endcase
            @(posedge clk);
            if (phase == LAST_PHASE || phase % 3 == 0)
                idle_pct = 0;
            else
                idle_pct = (phase % 3 == 1) ? 20 : 45;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                h = build_header();
                send_header(h, 1'b0, '0);
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
